[src/pcsf_pkg.sv]
// Shared types, widths and constants for the PWM capture to SBUS frame block.
// No dependencies; compile first.
`timescale 1ns / 1ps

package pcsf_pkg;

    localparam int PIN_COUNT        = 6;
    localparam int NUM_CHANNELS_DEF = 6;
    localparam int SBUS_CHANNELS    = 16;
    localparam int FRAME_LEN        = 25;
    localparam int BYTE_W           = 8;
    localparam int FRAME_W          = FRAME_LEN * BYTE_W;
    localparam int CHAN_W           = 11;
    localparam int WIDTH_W          = 16;
    localparam int TIME_W           = 16;
    localparam int PERIOD_W         = 20;
    localparam int FLAGS_W          = 8;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 20;

    localparam logic [BYTE_W-1:0]   START_BYTE    = 8'h0F;
    localparam logic [BYTE_W-1:0]   END_BYTE      = 8'h00;
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN     = 16'd1000;
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX     = 16'd2000;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET   = 16'd1500;
    localparam logic [CHAN_W-1:0]   SBUS_OFFSET   = 11'd172;

    // (w - 1000) * 1639 / 1000 == (span * MAP_MUL) >> MAP_SHIFT for span 0..1000
    localparam int                  SPAN_W        = 10;
    localparam logic [SPAN_W-1:0]   SPAN_MAX      = 10'd1000;
    localparam int                  MAP_MUL_W     = 23;
    localparam logic [MAP_MUL_W-1:0] MAP_MUL      = 23'd6874465;
    localparam int                  MAP_SHIFT     = 22;
    localparam int                  PROD_W        = SPAN_W + MAP_MUL_W;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 20'd14000;
    localparam logic [CHAN_W-1:0]   FILL_RESET    = 11'd1024;
    localparam logic [FLAGS_W-1:0]  FLAGS_RESET   = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD = 2'd0,
        CFG_FILL   = 2'd1,
        CFG_FLAGS  = 2'd2
    } t_cfg_idx;

    // Per-tick strobes fanned out to every lane
    typedef struct packed {
        logic tick;   // accepted pin sample: update stamps and widths
        logic map;    // register scaled width product
        logic scale;  // register offset channel value
    } t_lane_ctl;

endpackage

[src/pcsf_if.sv]
// Stream interfaces: pin samples in, SBUS frame bytes out.
// Depends on pcsf_pkg.
`timescale 1ns / 1ps

interface pcsf_tick_if;
    import pcsf_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [PIN_COUNT-1:0] pin_levels;
    modport source (output valid, output pin_levels, input ready);
    modport sink   (input valid, input pin_levels, output ready);
endinterface

interface pcsf_byte_if;
    import pcsf_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              last;
    modport source (output valid, output frame_byte, output last, input ready);
    modport sink   (input valid, input frame_byte, input last, output ready);
endinterface

[src/pwm_capture_to_sbus_frame.sv]
// Top level of the PWM capture to SBUS frame converter.
// Depends on pcsf_pkg, pcsf_if, pcsf_lane, pcsf_merge.
`timescale 1ns / 1ps
//
//  channel    dir  handshake            payload
//  ---------  ---  -------------------  --------------------------------
//  i_tick     in   valid / ready        pin_levels[5:0], one tick a word
//  o_frame    out  valid / ready        frame_byte[7:0], last
//  i_cfg_*    in   i_cfg_we (no wait)   i_cfg_idx, i_cfg_data[19:0]
//
// One tick word is taken every cycle but for the wait below. A tick that closes
// a frame period starts the lane pipeline (scale multiply, offset, merge into
// the frame register); the first frame byte shows once it is merged, then one
// byte per accepted word on o_frame. Only a frame-closing tick waits: it holds
// off while the previous frame is still in the pipeline or being drained, which
// the single frame register sets. Ticks that close no frame never stall.
// Reset is synchronous, active low, and ready stays low while it is asserted.

module pwm_capture_to_sbus_frame #(
    parameter int NUM_CHANNELS = pcsf_pkg::NUM_CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pcsf_tick_if.sink                       i_tick,
    pcsf_byte_if.source                     o_frame,
    input  logic                            i_cfg_we,
    input  logic [pcsf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pcsf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pcsf_pkg::*;

    // pins past the channel count are never sent, so they get no lane
    localparam int NUM_LANES = (NUM_CHANNELS < PIN_COUNT) ? NUM_CHANNELS : PIN_COUNT;

    logic [PERIOD_W-1:0]  r_period;
    logic [CHAN_W-1:0]    r_fill;
    logic [FLAGS_W-1:0]   r_flags;
    logic [TIME_W-1:0]    r_time;
    logic [NUM_LANES-1:0] r_prior;
    logic [PERIOD_W-1:0]  r_timer;
    logic                 r_map;
    logic                 r_scale;
    logic                 r_load;

    logic [PERIOD_W-1:0]  w_timer_inc;
    logic                 w_trig;
    logic                 w_fire;
    logic                 w_busy;
    t_lane_ctl            w_ctl;
    logic [CHAN_W-1:0]    w_chan [NUM_LANES];

    // configuration registers; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_fill   <= FILL_RESET;
            r_flags  <= FLAGS_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PERIOD: r_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_FILL:   r_fill   <= i_cfg_data[CHAN_W-1:0];
                CFG_FLAGS:  r_flags  <= i_cfg_data[FLAGS_W-1:0];
                default:    ;
            endcase
        end
    end

    // this tick closes the frame period (a zero period fires every tick)
    assign w_timer_inc = r_timer + 1'b1;
    assign w_trig      = (w_timer_inc >= r_period);

    // hold a frame-closing tick while the frame path is occupied
    assign i_tick.ready = i_rst_n && !(w_trig && (r_map || r_scale || r_load || w_busy));
    assign w_fire       = i_tick.valid && i_tick.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time  <= '0;
            r_prior <= '0;
            r_timer <= '0;
            r_map   <= 1'b0;
            r_scale <= 1'b0;
            r_load  <= 1'b0;
        end else begin
            r_map   <= w_fire && w_trig;
            r_scale <= r_map;
            r_load  <= r_scale;
            if (w_fire) begin
                r_time  <= r_time + 1'b1;
                r_prior <= i_tick.pin_levels[NUM_LANES-1:0];
                r_timer <= w_trig ? '0 : w_timer_inc;
            end
        end
    end

    assign w_ctl.tick  = w_fire;
    assign w_ctl.map   = r_map;
    assign w_ctl.scale = r_scale;

    // one capture lane per sent pin, all working on the same tick
    for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
        pcsf_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_level (i_tick.pin_levels[j]),
            .i_prior (r_prior[j]),
            .i_time  (r_time),
            .o_chan  (w_chan[j])
        );
    end

    // merge lane results with fill and flags, then serialize the frame
    pcsf_merge #(
        .NUM_LANES (NUM_LANES)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_load),
        .i_chan  (w_chan),
        .i_fill  (r_fill),
        .i_flags (r_flags),
        .o_busy  (w_busy),
        .o_frame (o_frame)
    );

endmodule

[src/pcsf_lane.sv]
// One capture lane: edge stamps, pulse width, and the width-to-SBUS mapping.
// Depends on pcsf_pkg.
`timescale 1ns / 1ps

module pcsf_lane (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pcsf_pkg::t_lane_ctl       i_ctl,
    input  logic                      i_level,
    input  logic                      i_prior,
    input  logic [pcsf_pkg::TIME_W-1:0] i_time,
    output logic [pcsf_pkg::CHAN_W-1:0] o_chan
);
    import pcsf_pkg::*;

    logic [TIME_W-1:0]  r_stamp;
    logic [WIDTH_W-1:0] r_width;
    logic [CHAN_W-1:0]  r_q;
    logic [CHAN_W-1:0]  r_chan;
    logic [SPAN_W-1:0]  w_span;
    logic [PROD_W-1:0]  w_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp <= '0;
            r_width <= WIDTH_RESET;
        end else if (i_ctl.tick && (i_level != i_prior)) begin
            if (i_level) begin
                r_stamp <= i_time;
            end else begin
                r_width <= WIDTH_W'(i_time - r_stamp);
            end
        end
    end

    // clamp to 1000..2000 and rebase to zero
    always_comb begin
        if (r_width < WIDTH_MIN) begin
            w_span = '0;
        end else if (r_width > WIDTH_MAX) begin
            w_span = SPAN_MAX;
        end else begin
            w_span = SPAN_W'(r_width - WIDTH_MIN);
        end
    end

    assign w_prod = PROD_W'(w_span) * PROD_W'(MAP_MUL);

    always_ff @(posedge i_clk) begin
        if (i_ctl.map) begin
            r_q <= w_prod[MAP_SHIFT +: CHAN_W];
        end
        if (i_ctl.scale) begin
            r_chan <= r_q + SBUS_OFFSET;
        end
    end

    assign o_chan = r_chan;

endmodule

[src/pcsf_merge.sv]
// Frame merge and byte serializer: packs lane results into a 25-byte frame
// and shifts it out one word per handshake. Depends on pcsf_pkg, pcsf_if.
`timescale 1ns / 1ps

module pcsf_merge #(
    parameter int NUM_LANES = pcsf_pkg::NUM_CHANNELS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [pcsf_pkg::CHAN_W-1:0]  i_chan [NUM_LANES],
    input  logic [pcsf_pkg::CHAN_W-1:0]  i_fill,
    input  logic [pcsf_pkg::FLAGS_W-1:0] i_flags,
    output logic                         o_busy,
    pcsf_byte_if.source                  o_frame
);
    import pcsf_pkg::*;

    localparam int IDX_W = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

    logic [CHAN_W-1:0]               w_slot [SBUS_CHANNELS];
    logic [SBUS_CHANNELS*CHAN_W-1:0] w_bits;
    logic [FRAME_W-1:0]              w_frame;
    logic [FRAME_W-1:0]              r_frame;
    logic [IDX_W-1:0]                r_idx;
    logic                            r_busy;

    // channels past the lanes carry the fill value
    for (genvar k = 0; k < SBUS_CHANNELS; k++) begin : g_slot
        if (k < NUM_LANES) begin : g_lane
            assign w_slot[k] = i_chan[k];
        end else begin : g_fill
            assign w_slot[k] = i_fill;
        end
        assign w_bits[k*CHAN_W +: CHAN_W] = w_slot[k];
    end

    assign w_frame = {END_BYTE, i_flags, w_bits, START_BYTE};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && o_frame.ready) begin
            r_idx <= r_idx + 1'b1;
            if (r_idx == LAST_IDX) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frame <= w_frame;
        end else if (r_busy && o_frame.ready) begin
            r_frame <= r_frame >> BYTE_W;
        end
    end

    assign o_frame.valid      = r_busy;
    assign o_frame.frame_byte = r_frame[BYTE_W-1:0];
    assign o_frame.last       = (r_idx == LAST_IDX);
    assign o_busy             = r_busy;

endmodule

[src/pcsf_checker.sv]
// Port-level checks on the frame output of pwm_capture_to_sbus_frame,
// attached by bind. Depends on pcsf_pkg and the top level.
`timescale 1ns / 1ps

module pcsf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic [pcsf_pkg::BYTE_W-1:0]  i_byte,
    input logic                         i_last
);
    import pcsf_pkg::*;

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_byte) && $stable(i_last)))
        else $error("frame word changed while stalled");

    // every frame opens with the start byte
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_valid) |-> (i_byte == START_BYTE && !i_last))
        else $error("frame does not open with start byte");

    // closing word is the end byte
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_last) |-> (i_byte == END_BYTE))
        else $error("last word is not the end byte");

    // frames never run together
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ready && i_last) |=> !i_valid)
        else $error("new frame started right after last word");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid after reset");

endmodule

bind pwm_capture_to_sbus_frame pcsf_checker u_pcsf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_frame.valid),
    .i_ready (o_frame.ready),
    .i_byte  (o_frame.frame_byte),
    .i_last  (o_frame.last)
);
